FILE: rtl/core/slsq_pkg.sv
// slsq_pkg: shared types and codes for the scissor lift sequencer
// word layouts, phase/mode/event/selector codes, drive bit positions
// no dependencies
`default_nettype none

package slsq_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CFG_VALVE_DELAY = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD        = 4'd1;

  localparam logic [15:0] VALVE_DELAY_RESET = 16'd500;
  localparam logic [15:0] HOLD_RESET        = 16'd1000;
  localparam logic [15:0] DUR_MAX           = 16'hFFFF;

  // drive bit positions
  localparam int DRV_MOTOR = 0;
  localparam int DRV_DROP  = 1;
  localparam int DRV_AIR   = 2;

  typedef enum logic [1:0] {
    FUNC_POLL  = 2'd0,
    FUNC_ESTOP = 2'd1,
    FUNC_BEAM  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RISING    = 3'd1,
    PH_DOWN_PREP = 3'd2,
    PH_DOWN_HOLD = 3'd3,
    PH_DROPPING  = 3'd4,
    PH_LOCKING   = 3'd5,
    PH_REFILLING = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_RISING    = 3'd1,
    MODE_DROPPING  = 3'd2,
    MODE_LOCKED    = 3'd3,
    MODE_REFILLING = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    EV_NONE         = 4'd0,
    EV_UP_START     = 4'd1,
    EV_UP_LIMIT     = 4'd2,
    EV_UP_RELEASE   = 4'd3,
    EV_DOWN_START   = 4'd4,
    EV_DOWN_RELEASE = 4'd5,
    EV_LOCK_START   = 4'd6,
    EV_LOCK_STOP    = 4'd7,
    EV_REFILL_START = 4'd8,
    EV_REFILL_STOP  = 4'd9,
    EV_INVALID      = 4'd10
  } event_t;

  typedef struct packed {
    logic [1:0]  func;
    logic        up_button;
    logic        down_button;
    logic        lock_button;
    logic        refill_button;
    logic        top_switch;
    logic        bottom_switch;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic        motor_on;
    logic        drop_valve_on;
    logic        air_valve_on;
    logic [2:0]  lift_mode;
    logic [2:0]  phase;
    logic [3:0]  log_event;
    logic [15:0] log_duration;
  } out_word_t;

  // sequencer state carried between words
  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  mode;
    logic [2:0]  drive;
    logic [31:0] start_time;
    logic        prev_up;
    logic        prev_down;
    logic        prev_lock;
  } seq_state_t;

  typedef struct packed {
    logic [15:0] valve_delay_ms;
    logic [15:0] hold_ms;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/slsq_step.sv
// slsq_step: combinational update of the lift sequencer for one word
// takes current state, config and input word; gives next state and result
// depends on slsq_pkg
`default_nettype none

module slsq_step (
  input  var slsq_pkg::seq_state_t st,
  input  var slsq_pkg::cfg_t       cfg,
  input  var slsq_pkg::in_word_t   word,
  output var slsq_pkg::seq_state_t nxt,
  output var slsq_pkg::out_word_t  result
);

  logic [31:0] elapsed;
  logic [15:0] sat_dur;
  logic        up, dn, lk, rf, top, bot;
  logic [3:0]  ev;
  logic        is_stop;

  assign up  = word.up_button;
  assign dn  = word.down_button;
  assign lk  = word.lock_button;
  assign rf  = word.refill_button;
  assign top = word.top_switch;
  assign bot = word.bottom_switch;

  // elapsed time, wraps modulo 2^32, saturated for logging
  assign elapsed = word.now_ms - st.start_time;
  assign sat_dur = (elapsed[31:16] != 16'd0) ? slsq_pkg::DUR_MAX : elapsed[15:0];

  // lock drive: drop valve, air valve unless at the bottom
  function automatic logic [2:0] lock_drive(input logic at_bottom);
    logic [2:0] d;
    d = '0;
    d[slsq_pkg::DRV_DROP] = 1'b1;
    d[slsq_pkg::DRV_AIR]  = ~at_bottom;
    return d;
  endfunction

  // next state
  always_comb begin
    nxt = st;
    if (word.func == slsq_pkg::FUNC_ESTOP || word.func == slsq_pkg::FUNC_BEAM) begin
      nxt.drive = '0;
      nxt.phase = slsq_pkg::PH_IDLE;
    end else if (word.func == slsq_pkg::FUNC_CLEAR) begin
      nxt.phase = slsq_pkg::PH_IDLE;
    end else begin
      nxt.prev_up   = up;
      nxt.prev_down = dn;
      nxt.prev_lock = lk;
      if (up && dn) begin
        nxt.drive = '0;
        if (st.phase != slsq_pkg::PH_IDLE) begin
          nxt.phase = slsq_pkg::PH_IDLE;
          nxt.mode  = slsq_pkg::MODE_IDLE;
        end
      end else begin
        case (st.phase)
          slsq_pkg::PH_IDLE: begin
            if (up && rf && !dn && !lk) begin
              nxt.drive      = 3'b000;
              nxt.drive[slsq_pkg::DRV_MOTOR] = 1'b1;
              nxt.start_time = word.now_ms;
              nxt.phase      = slsq_pkg::PH_REFILLING;
              nxt.mode       = slsq_pkg::MODE_REFILLING;
            end else if (lk && !st.prev_lock) begin
              nxt.drive      = lock_drive(bot);
              nxt.start_time = word.now_ms;
              nxt.phase      = slsq_pkg::PH_LOCKING;
              nxt.mode       = slsq_pkg::MODE_LOCKED;
            end else if (up && !st.prev_up && !dn && !lk && !top) begin
              nxt.drive[slsq_pkg::DRV_MOTOR] = 1'b1;
              nxt.start_time = word.now_ms;
              nxt.phase      = slsq_pkg::PH_RISING;
              nxt.mode       = slsq_pkg::MODE_RISING;
            end else if (dn && !st.prev_down) begin
              nxt.drive[slsq_pkg::DRV_MOTOR] = 1'b1;
              nxt.start_time = word.now_ms;
              nxt.phase      = slsq_pkg::PH_DOWN_PREP;
              nxt.mode       = slsq_pkg::MODE_DROPPING;
            end
          end
          slsq_pkg::PH_RISING: begin
            if (top || !up) begin
              nxt.drive = '0;
              nxt.phase = slsq_pkg::PH_IDLE;
              nxt.mode  = slsq_pkg::MODE_IDLE;
            end
          end
          slsq_pkg::PH_DOWN_PREP, slsq_pkg::PH_DOWN_HOLD, slsq_pkg::PH_DROPPING: begin
            if (!dn) begin
              nxt.drive = '0;
              nxt.phase = slsq_pkg::PH_IDLE;
              nxt.mode  = slsq_pkg::MODE_IDLE;
            end else if (bot) begin
              nxt.drive = '0;
              nxt.drive[slsq_pkg::DRV_DROP] = 1'b1;
              nxt.phase = slsq_pkg::PH_DROPPING;
              nxt.mode  = slsq_pkg::MODE_DROPPING;
            end else if (top || lk) begin
              nxt.drive = lock_drive(1'b0);
              nxt.phase = slsq_pkg::PH_DROPPING;
              nxt.mode  = slsq_pkg::MODE_DROPPING;
            end else if (st.phase == slsq_pkg::PH_DOWN_PREP) begin
              if (elapsed >= {16'd0, cfg.valve_delay_ms}) begin
                nxt.drive[slsq_pkg::DRV_AIR] = 1'b1;
                nxt.phase = slsq_pkg::PH_DOWN_HOLD;
              end
            end else if (st.phase == slsq_pkg::PH_DOWN_HOLD) begin
              if (elapsed >= {16'd0, cfg.hold_ms}) begin
                nxt.drive[slsq_pkg::DRV_MOTOR] = 1'b0;
                nxt.drive[slsq_pkg::DRV_DROP]  = 1'b1;
                nxt.phase = slsq_pkg::PH_DROPPING;
              end
            end
          end
          slsq_pkg::PH_LOCKING: begin
            if (!lk) begin
              nxt.drive = '0;
              nxt.phase = slsq_pkg::PH_IDLE;
              nxt.mode  = slsq_pkg::MODE_IDLE;
            end else begin
              nxt.drive = lock_drive(bot);
            end
          end
          slsq_pkg::PH_REFILLING: begin
            if (!up || !rf || dn || lk) begin
              nxt.drive = '0;
              nxt.phase = slsq_pkg::PH_IDLE;
              nxt.mode  = slsq_pkg::MODE_IDLE;
            end
          end
          default: begin
            // unused phase code: stop everything
            nxt.drive = '0;
            nxt.phase = slsq_pkg::PH_IDLE;
            nxt.mode  = slsq_pkg::MODE_IDLE;
          end
        endcase
      end
    end
  end

  // log event for this word
  always_comb begin
    ev = slsq_pkg::EV_NONE;
    if (word.func == slsq_pkg::FUNC_POLL) begin
      if (up && dn) begin
        if (st.phase != slsq_pkg::PH_IDLE) begin
          ev = slsq_pkg::EV_INVALID;
        end
      end else begin
        case (st.phase)
          slsq_pkg::PH_IDLE: begin
            if (up && rf && !dn && !lk) begin
              ev = slsq_pkg::EV_REFILL_START;
            end else if (lk && !st.prev_lock) begin
              ev = slsq_pkg::EV_LOCK_START;
            end else if (up && !st.prev_up && !dn && !lk && !top) begin
              ev = slsq_pkg::EV_UP_START;
            end else if (dn && !st.prev_down) begin
              ev = slsq_pkg::EV_DOWN_START;
            end
          end
          slsq_pkg::PH_RISING: begin
            if (top) begin
              ev = slsq_pkg::EV_UP_LIMIT;
            end else if (!up) begin
              ev = slsq_pkg::EV_UP_RELEASE;
            end
          end
          slsq_pkg::PH_DOWN_PREP, slsq_pkg::PH_DOWN_HOLD, slsq_pkg::PH_DROPPING: begin
            if (!dn) begin
              ev = slsq_pkg::EV_DOWN_RELEASE;
            end
          end
          slsq_pkg::PH_LOCKING: begin
            if (!lk) begin
              ev = slsq_pkg::EV_LOCK_STOP;
            end
          end
          slsq_pkg::PH_REFILLING: begin
            if (!up || !rf || dn || lk) begin
              ev = slsq_pkg::EV_REFILL_STOP;
            end
          end
          default: begin
            ev = slsq_pkg::EV_NONE;
          end
        endcase
      end
    end
  end

  // stop events carry the elapsed time
  assign is_stop = (ev == slsq_pkg::EV_UP_LIMIT)   || (ev == slsq_pkg::EV_UP_RELEASE) ||
                   (ev == slsq_pkg::EV_DOWN_RELEASE) || (ev == slsq_pkg::EV_LOCK_STOP) ||
                   (ev == slsq_pkg::EV_REFILL_STOP);

  // result word
  always_comb begin
    result.motor_on      = nxt.drive[slsq_pkg::DRV_MOTOR];
    result.drop_valve_on = nxt.drive[slsq_pkg::DRV_DROP];
    result.air_valve_on  = nxt.drive[slsq_pkg::DRV_AIR];
    result.lift_mode     = nxt.mode;
    result.phase         = nxt.phase;
    result.log_event     = ev;
    result.log_duration  = is_stop ? sat_dur : 16'd0;
  end

endmodule

`default_nettype wire

FILE: rtl/core/scissor_lift_sequencer.sv
// scissor_lift_sequencer: top level of the hydraulic scissor lift sequencer
// input register, step logic, result register, config registers
// depends on slsq_pkg and slsq_step
//
// Usage:
//   in channel (in_valid/in_stall/in_data) carries one input word per event:
//   selector, button and switch levels and a millisecond time stamp.
//   out channel (out_valid/out_stall/out_data) carries one result word per
//   input word: drive outputs, lift mode, phase, log event and duration.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the valve
//   delay (index 0) and hold time (index 1); cfg_ready is always high and
//   writes to other indexes are dropped. Write only while the block is idle.
// Timing:
//   a word accepted into the input register has its result loaded into the
//   output register when the input register advances; out_stall can hold it.
//   one word per cycle sustained while out_stall is low; the state update is a
//   single pass of the step logic between the input and output registers.
// Reset (rst, synchronous): both registers empty, sequencer idle with all
//   drives off, config back to 500 ms valve delay and 1000 ms hold.
// Stall: while out_stall holds a waiting result, the input register keeps
//   its word and in_stall rises once that register is full.
`default_nettype none

module scissor_lift_sequencer (
  input  var logic                         clk,
  input  var logic                         rst,
  input  var logic                         in_valid,
  output var logic                         in_stall,
  input  var slsq_pkg::in_word_t           in_data,
  output var logic                         out_valid,
  input  var logic                         out_stall,
  output var slsq_pkg::out_word_t          out_data,
  input  var logic                         cfg_valid,
  output var logic                         cfg_ready,
  input  var logic [slsq_pkg::CfgIdxW-1:0] cfg_index,
  input  var logic [15:0]                  cfg_data
);

  logic                 stage_valid;
  slsq_pkg::in_word_t   stage_word;
  logic                 advance;
  slsq_pkg::seq_state_t st;
  slsq_pkg::seq_state_t st_next;
  slsq_pkg::cfg_t       cfg;
  slsq_pkg::out_word_t  result;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.valve_delay_ms <= slsq_pkg::VALVE_DELAY_RESET;
      cfg.hold_ms        <= slsq_pkg::HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == slsq_pkg::CFG_VALVE_DELAY) begin
        cfg.valve_delay_ms <= cfg_data;
      end else if (cfg_index == slsq_pkg::CFG_HOLD) begin
        cfg.hold_ms <= cfg_data;
      end
    end
  end

  // input register moves on when the output register is free or draining
  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_word <= in_data;
    end
  end

  slsq_step u_step (
    .st     (st),
    .cfg    (cfg),
    .word   (stage_word),
    .nxt    (st_next),
    .result (result)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // a word that advances from the input register reaches the output register
  assert property (@(posedge clk) disable iff (rst) advance |=> out_valid)
    else $error("result word lost after advance");

  // a held word stays in the input register
  assert property (@(posedge clk) disable iff (rst) (stage_valid && !advance) |=> stage_valid)
    else $error("stalled input word dropped");

  // duration only on stop events
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.log_duration != 16'd0) |->
      (out_data.log_event == slsq_pkg::EV_UP_LIMIT ||
       out_data.log_event == slsq_pkg::EV_UP_RELEASE ||
       out_data.log_event == slsq_pkg::EV_DOWN_RELEASE ||
       out_data.log_event == slsq_pkg::EV_LOCK_STOP ||
       out_data.log_event == slsq_pkg::EV_REFILL_STOP))
    else $error("log duration on a non-stop event");

  // nothing is pending right after reset
  assert property (@(posedge clk) rst |=> (!out_valid && !stage_valid))
    else $error("registers not empty after reset");

endmodule

`default_nettype wire
